### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the wall column renderer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define TWCR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twcr: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define TWCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twcr: assertion failed");

`endif

### src/twcr_pkg.sv
// ----------------------------------------------------------------------------
// twcr_pkg
// Types and fixed constants of the textured wall column renderer.
// ----------------------------------------------------------------------------
package twcr_pkg;

   localparam int ROW_W      = 6;
   localparam int Y_W        = ROW_W + 1;
   localparam int COL_W      = 10;
   localparam int SEL_W      = 2;
   localparam int TADDR_W    = 12;
   localparam int TEXEL_W    = 32;
   localparam int DIST_W     = 16;
   localparam int COORD_W    = 16;
   localparam int SIZE_W     = 7;
   localparam int HGT_W      = 16;
   localparam int TROW_W     = 8;
   localparam int DIV_NUM_W  = 24;
   localparam int DIV_DEN_W  = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam logic [1:0] REG_HORIZON    = 2'd0;
   localparam logic [1:0] REG_TEX_WIDTH  = 2'd1;
   localparam logic [1:0] REG_TEX_HEIGHT = 2'd2;

   localparam logic [ROW_W-1:0]  HORIZON_RESET = 6'd32;
   localparam logic [SIZE_W-1:0] SIZE_RESET    = 7'd64;

   typedef struct packed {
      logic                command;
      logic [SEL_W-1:0]    texture_select;
      logic [TADDR_W-1:0]  texel_address;
      logic [TEXEL_W-1:0]  texel_value;
      logic [COL_W-1:0]    column;
      logic [DIST_W-1:0]   distance;
      logic [COORD_W-1:0]  wall_coord;
   } req_payload_type;

   typedef struct packed {
      logic [COL_W-1:0]    pixel_column;
      logic [ROW_W-1:0]    pixel_row;
      logic [TEXEL_W-1:0]  pixel_color;
      logic                last_pixel;
   } rsp_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0]  horizon_row;
      logic [SIZE_W-1:0] texture_width;
      logic [SIZE_W-1:0] texture_height;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numerator;
      logic [DIV_DEN_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic [DIV_DEN_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [1:0] level;
      logic       pop;
   } queue_status_type;

endpackage

### src/twcr_csr.sv
// ----------------------------------------------------------------------------
// twcr_csr
// Configuration registers with texture size clamping for the renderer.
// ----------------------------------------------------------------------------
module twcr_csr #(
   parameter int TEX_SIZE = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [twcr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [twcr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [twcr_pkg::CSR_DATA_W-1:0]     prdata,
   output twcr_pkg::cfg_type                   cfg
);

   localparam int SIZE_CAP = (TEX_SIZE > 127) ? 127 : TEX_SIZE;

   logic [twcr_pkg::ROW_W-1:0]  horizon_ff, horizon_in;
   logic [twcr_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [twcr_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [1:0]                  reg_idx;
   logic                        wr_en;

   function automatic logic [twcr_pkg::SIZE_W-1:0] clamp_size(
      input logic [twcr_pkg::SIZE_W-1:0] v
   );
      logic [twcr_pkg::SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = twcr_pkg::SIZE_W'(1);
      end else if (int'(v) > SIZE_CAP) begin
         r = twcr_pkg::SIZE_W'(SIZE_CAP);
      end
      return r;
   endfunction

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      horizon_in = horizon_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      if (wr_en) begin
         unique case (reg_idx)
            twcr_pkg::REG_HORIZON:    horizon_in = pwdata[twcr_pkg::ROW_W-1:0];
            twcr_pkg::REG_TEX_WIDTH:  width_in   = pwdata[twcr_pkg::SIZE_W-1:0];
            twcr_pkg::REG_TEX_HEIGHT: height_in  = pwdata[twcr_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= twcr_pkg::HORIZON_RESET;
         width_ff   <= twcr_pkg::SIZE_RESET;
         height_ff  <= twcr_pkg::SIZE_RESET;
      end else begin
         horizon_ff <= horizon_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         twcr_pkg::REG_HORIZON:    prdata = twcr_pkg::CSR_DATA_W'(horizon_ff);
         twcr_pkg::REG_TEX_WIDTH:  prdata = twcr_pkg::CSR_DATA_W'(width_ff);
         twcr_pkg::REG_TEX_HEIGHT: prdata = twcr_pkg::CSR_DATA_W'(height_ff);
         default:                  prdata = '0;
      endcase
   end

   assign cfg.horizon_row    = horizon_ff;
   assign cfg.texture_width  = clamp_size(width_ff);
   assign cfg.texture_height = clamp_size(height_ff);

endmodule

### src/twcr_div.sv
// ----------------------------------------------------------------------------
// twcr_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twcr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  twcr_pkg::div_req_type req,
   output twcr_pkg::div_rsp_type rsp
);

   localparam int NUM_W = twcr_pkg::DIV_NUM_W;
   localparam int DEN_W = twcr_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(NUM_W);
         quot_in  = req.numerator;
         rem_in   = '0;
         den_in   = req.denominator;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in  = diff[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quot_ff;
   assign rsp.remainder = rem_ff;

endmodule

### src/twcr_tex_store.sv
// ----------------------------------------------------------------------------
// twcr_tex_store
// Texture memory for four textures, one write and one registered read port.
// ----------------------------------------------------------------------------
module twcr_tex_store #(
   parameter int TEX_SIZE = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [twcr_pkg::SEL_W-1:0]             wr_select,
   input  logic [twcr_pkg::TADDR_W-1:0]           wr_address,
   input  logic [twcr_pkg::TEXEL_W-1:0]           wr_data,
   input  logic                                   rd_en,
   input  logic [twcr_pkg::SEL_W-1:0]             rd_select,
   input  logic [$clog2(TEX_SIZE*TEX_SIZE)-1:0]   rd_index,
   output logic [twcr_pkg::TEXEL_W-1:0]           rd_data
);

   localparam int TEX_WORDS = TEX_SIZE * TEX_SIZE;
   localparam int DEPTH     = 4 * TEX_WORDS;
   localparam int ADDR_W    = $clog2(DEPTH);

   logic [twcr_pkg::TEXEL_W-1:0] mem_ff [DEPTH];
   logic [twcr_pkg::TEXEL_W-1:0] rd_data_ff;
   logic                         wr_in_range;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;

   assign wr_in_range = 32'(wr_address) < TEX_WORDS;
   assign wr_addr = ADDR_W'(wr_select) * ADDR_W'(TEX_WORDS) + ADDR_W'(wr_address);
   assign rd_addr = ADDR_W'(rd_select) * ADDR_W'(TEX_WORDS) + ADDR_W'(rd_index);

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/twcr_out_queue.sv
// ----------------------------------------------------------------------------
// twcr_out_queue
// Two-entry result queue between the texture read and the result channel.
// ----------------------------------------------------------------------------
module twcr_out_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  twcr_pkg::rsp_payload_type   push_data,
   input  logic                        stall,
   output logic                        valid,
   output twcr_pkg::rsp_payload_type   data,
   output twcr_pkg::queue_status_type  status
);

   twcr_pkg::rsp_payload_type entry_ff [twcr_pkg::QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       pop;

   assign valid = (count_ff != 2'd0);
   assign pop   = valid && !stall;

   always_comb begin
      count_in  = count_ff + 2'(push) - 2'(pop);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign data         = entry_ff[rd_ptr_ff];
   assign status.level = count_ff;
   assign status.pop   = pop;

endmodule

### src/textured_wall_column_renderer.sv
// ----------------------------------------------------------------------------
// textured_wall_column_renderer: a draw runs setup (up to three passes of the shared
// divider), then reads one texel per cycle from the single texture read port while the
// result queue has room; each texel is registered at the port and queued before its pixel
// shows. Synchronous reset clears control and sets the registers to 32, 64, 64; texture
// memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module textured_wall_column_renderer #(
   parameter int SCREEN_HEIGHT = 64,
   parameter int SCREEN_WIDTH  = 1024,
   parameter int TEX_SIZE      = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  twcr_pkg::req_payload_type          req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output twcr_pkg::rsp_payload_type          rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [twcr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [twcr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [twcr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W  = $clog2(TEX_SIZE * TEX_SIZE);
   localparam int NUM_W  = twcr_pkg::DIV_NUM_W;
   localparam int HGT_W  = twcr_pkg::HGT_W;
   localparam int Y_W    = twcr_pkg::Y_W;
   localparam int ROW_W  = twcr_pkg::ROW_W;
   localparam int SIZE_W = twcr_pkg::SIZE_W;
   localparam int TROW_W = twcr_pkg::TROW_W;
   localparam logic [NUM_W-1:0] SCREEN_NUM = NUM_W'(SCREEN_HEIGHT * 256);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HDIV  = 4'd1;
   localparam logic [3:0] S_HWAIT = 4'd2;
   localparam logic [3:0] S_SPAN  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_QDIV  = 4'd5;
   localparam logic [3:0] S_QWAIT = 4'd6;
   localparam logic [3:0] S_SDIV  = 4'd7;
   localparam logic [3:0] S_SWAIT = 4'd8;
   localparam logic [3:0] S_PIX   = 4'd9;

   twcr_pkg::cfg_type          cfg;
   twcr_pkg::div_req_type      div_req;
   twcr_pkg::div_rsp_type      div_rsp;
   twcr_pkg::queue_status_type queue_status;
   twcr_pkg::rsp_payload_type  push_data;

   logic [3:0]                     state_ff, state_in;
   logic [twcr_pkg::SEL_W-1:0]     sel_ff, sel_in;
   logic [twcr_pkg::COL_W-1:0]     column_ff, column_in;
   logic [twcr_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic [twcr_pkg::COORD_W-1:0]   coord_ff, coord_in;
   logic [HGT_W-1:0]               height_ff, height_in;
   logic [Y_W-1:0]                 y_ff, y_in;
   logic [Y_W-1:0]                 end_ff, end_in;
   logic [HGT_W-1:0]               off_ff, off_in;
   logic [SIZE_W-1:0]              tcol_ff, tcol_in;
   logic [NUM_W-1:0]               num0_ff, num0_in;
   logic [TROW_W-1:0]              q_ff, q_in;
   logic [HGT_W-1:0]               r_ff, r_in;
   logic [TROW_W-1:0]              qs_ff, qs_in;
   logic [HGT_W-1:0]               rs_ff, rs_in;
   logic                           inflight_ff, inflight_in;
   logic [ROW_W-1:0]               rd_row_ff, rd_row_in;
   logic                           rd_last_ff, rd_last_in;
   logic [twcr_pkg::COL_W-1:0]     rd_column_ff, rd_column_in;

   logic                           req_accept;
   logic                           load_en;
   logic signed [17:0]             span_diff;
   logic signed [17:0]             span_start;
   logic signed [17:0]             span_off_full;
   logic [16:0]                    span_end_raw;
   logic [Y_W-1:0]                 span_end;
   logic [ROW_W-1:0]               span_first;
   logic                           span_empty;
   logic [22:0]                    tcol_prod;
   logic [2:0]                     occupancy;
   logic                           issue;
   logic [SIZE_W-1:0]              trow;
   logic [13:0]                    idx_full;
   logic [IDX_W-1:0]               rd_index;
   logic [16:0]                    r_sum;
   logic                           row_last;
   logic [twcr_pkg::TEXEL_W-1:0]   texel;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_en    = req_accept && (req_payload.command == twcr_pkg::CMD_LOAD);
   assign csr_pready = 1'b1;

   assign span_diff  = $signed({11'b0, cfg.horizon_row, 1'b0}) - $signed({2'b0, height_ff});
   assign span_start = (span_diff + $signed({17'b0, span_diff[17]})) >>> 1;
   assign span_end_raw = 17'(cfg.horizon_row) + 17'(height_ff[HGT_W-1:1]);
   assign span_end = (span_end_raw > 17'(SCREEN_HEIGHT)) ? Y_W'(SCREEN_HEIGHT)
                                                         : span_end_raw[Y_W-1:0];
   assign span_first    = span_start[17] ? '0 : span_start[ROW_W-1:0];
   assign span_off_full = $signed({12'b0, span_first}) - span_start;
   assign span_empty    = (height_ff == '0) || ({1'b0, span_first} >= span_end);
   assign tcol_prod     = 23'(cfg.texture_width) * 23'(coord_ff);

   assign occupancy = 3'(queue_status.level) - 3'(queue_status.pop) + 3'(inflight_ff);
   assign issue     = (state_ff == S_PIX) && (occupancy < 3'(twcr_pkg::QUEUE_DEPTH));
   assign trow      = (q_ff >= TROW_W'(cfg.texture_height)) ?
                      (cfg.texture_height - 1'b1) : q_ff[SIZE_W-1:0];
   assign idx_full  = 14'(trow) * 14'(cfg.texture_width) + 14'(tcol_ff);
   assign rd_index  = IDX_W'(idx_full);
   assign r_sum     = 17'(r_ff) + 17'(rs_ff);
   assign row_last  = (y_ff + 1'b1) == end_ff;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      column_in    = column_ff;
      dist_in      = dist_ff;
      coord_in     = coord_ff;
      height_in    = height_ff;
      y_in         = y_ff;
      end_in       = end_ff;
      off_in       = off_ff;
      tcol_in      = tcol_ff;
      num0_in      = num0_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      qs_in        = qs_ff;
      rs_in        = rs_ff;
      inflight_in  = issue;
      rd_row_in    = rd_row_ff;
      rd_last_in   = rd_last_ff;
      rd_column_in = rd_column_ff;
      div_req.start       = 1'b0;
      div_req.numerator   = num0_ff;
      div_req.denominator = height_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_payload.command == twcr_pkg::CMD_DRAW) &&
                (32'(req_payload.column) < SCREEN_WIDTH)) begin
               sel_in    = req_payload.texture_select;
               column_in = req_payload.column;
               dist_in   = req_payload.distance;
               coord_in  = req_payload.wall_coord;
               state_in  = S_HDIV;
            end
         end
         S_HDIV: begin
            if (dist_ff == '0) begin
               height_in = '1;
               state_in  = S_SPAN;
            end else begin
               div_req.start       = 1'b1;
               div_req.numerator   = SCREEN_NUM;
               div_req.denominator = dist_ff;
               state_in            = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (div_rsp.done) begin
               height_in = div_rsp.quotient[HGT_W-1:0];
               state_in  = S_SPAN;
            end
         end
         S_SPAN: begin
            if (span_empty) begin
               state_in = S_IDLE;
            end else begin
               y_in     = Y_W'(span_first);
               end_in   = span_end;
               off_in   = span_off_full[HGT_W-1:0];
               tcol_in  = tcol_prod[22:16];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            num0_in  = NUM_W'(off_ff) * NUM_W'(cfg.texture_height);
            state_in = S_QDIV;
         end
         S_QDIV: begin
            if (num0_ff == '0) begin
               q_in     = '0;
               r_in     = '0;
               state_in = S_SDIV;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quotient[TROW_W-1:0];
               r_in     = div_rsp.remainder;
               state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            if (height_ff > HGT_W'(cfg.texture_height)) begin
               qs_in    = '0;
               rs_in    = HGT_W'(cfg.texture_height);
               state_in = S_PIX;
            end else begin
               div_req.start     = 1'b1;
               div_req.numerator = NUM_W'(cfg.texture_height);
               state_in          = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (div_rsp.done) begin
               qs_in    = div_rsp.quotient[TROW_W-1:0];
               rs_in    = div_rsp.remainder;
               state_in = S_PIX;
            end
         end
         S_PIX: begin
            if (issue) begin
               rd_row_in    = y_ff[ROW_W-1:0];
               rd_last_in   = row_last;
               rd_column_in = column_ff;
               y_in         = y_ff + 1'b1;
               if (r_sum >= 17'(height_ff)) begin
                  r_in = HGT_W'(r_sum - 17'(height_ff));
                  q_in = q_ff + qs_ff + 1'b1;
               end else begin
                  r_in = r_sum[HGT_W-1:0];
                  q_in = q_ff + qs_ff;
               end
               if (row_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff       <= sel_in;
      column_ff    <= column_in;
      dist_ff      <= dist_in;
      coord_ff     <= coord_in;
      height_ff    <= height_in;
      y_ff         <= y_in;
      end_ff       <= end_in;
      off_ff       <= off_in;
      tcol_ff      <= tcol_in;
      num0_ff      <= num0_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      qs_ff        <= qs_in;
      rs_ff        <= rs_in;
      rd_row_ff    <= rd_row_in;
      rd_last_ff   <= rd_last_in;
      rd_column_ff <= rd_column_in;
   end

   twcr_csr #(
      .TEX_SIZE (TEX_SIZE)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   twcr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   twcr_tex_store #(
      .TEX_SIZE (TEX_SIZE)
   ) u_tex_store (
      .clock      (clock),
      .wr_en      (load_en),
      .wr_select  (req_payload.texture_select),
      .wr_address (req_payload.texel_address),
      .wr_data    (req_payload.texel_value),
      .rd_en      (issue),
      .rd_select  (sel_ff),
      .rd_index   (rd_index),
      .rd_data    (texel)
   );

   assign push_data.pixel_column = rd_column_ff;
   assign push_data.pixel_row    = rd_row_ff;
   assign push_data.pixel_color  = texel;
   assign push_data.last_pixel   = rd_last_ff;

   twcr_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (inflight_ff),
      .push_data (push_data),
      .stall     (rsp_stall),
      .valid     (rsp_valid),
      .data      (rsp_payload),
      .status    (queue_status)
   );

endmodule

### src/twcr_checker.sv
// ----------------------------------------------------------------------------
// twcr_checker
// Port-level checks of the wall column renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twcr_checker #(
   parameter int SCREEN_HEIGHT = 64
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input twcr_pkg::rsp_payload_type          rsp_payload
);

   logic                            mid_ff, mid_in;
   logic [twcr_pkg::ROW_W-1:0]      prev_row_ff, prev_row_in;
   logic [twcr_pkg::COL_W-1:0]      prev_col_ff, prev_col_in;
   logic                            rsp_beat;
   logic                            row_follows;

   assign rsp_beat    = rsp_valid && !rsp_stall;
   assign row_follows = (rsp_payload.pixel_row == twcr_pkg::ROW_W'(prev_row_ff + 1'b1)) &&
                        (rsp_payload.pixel_column == prev_col_ff);

   always_comb begin
      mid_in      = mid_ff;
      prev_row_in = prev_row_ff;
      prev_col_in = prev_col_ff;
      if (rsp_beat) begin
         mid_in      = !rsp_payload.last_pixel;
         prev_row_in = rsp_payload.pixel_row;
         prev_col_in = rsp_payload.pixel_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else begin
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_row_ff <= prev_row_in;
      prev_col_ff <= prev_col_in;
   end

   `TWCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `TWCR_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `TWCR_ASSERT_IMPLY(a_row_range, clock, reset, rsp_valid, 32'(rsp_payload.pixel_row) < SCREEN_HEIGHT)
   `TWCR_ASSERT_IMPLY(a_row_step, clock, reset, rsp_valid && mid_ff, row_follows)

endmodule

bind textured_wall_column_renderer twcr_checker #(
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_twcr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the textured wall column renderer
// Drives load and draw beats and predicts every pixel of each drawn column
// from its own copy of the texture memory and the three registers. Each
// pixel beat is compared field by field with the oldest predicted pixel.
// The registers are rewritten between phases while the block is idle.
// Both channels idle at random, the receiver holds off once for a long
// stretch, and the sender pauses once per phase until all pixels are back.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SCREEN_HEIGHT = 64;
   localparam int SCREEN_WIDTH  = 1024;
   localparam int TEX_SIZE      = 64;
   localparam int TEX_WORDS     = TEX_SIZE * TEX_SIZE;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic                      pause_here;
      twcr_pkg::req_payload_type beat;
   } stimulus_entry_type;

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   twcr_pkg::req_payload_type       req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   twcr_pkg::rsp_payload_type       rsp_payload;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [twcr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [twcr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [twcr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   stimulus_entry_type        beats_to_send [$];
   twcr_pkg::rsp_payload_type expected_pixels [$];

   logic [twcr_pkg::TEXEL_W-1:0] texture_mem [0:4*TEX_WORDS-1];
   bit                           texel_loaded [0:4*TEX_WORDS-1];
   logic [twcr_pkg::ROW_W-1:0]   horizon_reg = twcr_pkg::HORIZON_RESET;
   logic [twcr_pkg::SIZE_W-1:0]  width_reg   = twcr_pkg::SIZE_RESET;
   logic [twcr_pkg::SIZE_W-1:0]  height_reg  = twcr_pkg::SIZE_RESET;

   logic [twcr_pkg::ROW_W-1:0]   span_row [0:SCREEN_HEIGHT-1];
   logic [twcr_pkg::TADDR_W-1:0] span_index [0:SCREEN_HEIGHT-1];

   int mismatch_count = 0;
   int beats_queued   = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   bit hold_request   = 1'b0;
   bit hold_taken     = 1'b0;

   textured_wall_column_renderer #(
      .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .TEX_SIZE     (TEX_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int size_used(input logic [twcr_pkg::SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > TEX_SIZE) return TEX_SIZE;
      return int'(v);
   endfunction

   // Fills span_row and span_index with the visible rows of a draw and the
   // texel each one reads; returns the number of rows.
   function automatic int trace_column(input twcr_pkg::req_payload_type r);
      int tw, th, hu, hz, first, stop, y, tcol, trow, n;
      n = 0;
      if (r.command != twcr_pkg::CMD_DRAW || int'(r.column) >= SCREEN_WIDTH) return 0;
      tw = size_used(width_reg);
      th = size_used(height_reg);
      if (r.distance == 0) begin
         hu = 65535;
      end else begin
         hu = (SCREEN_HEIGHT * 256) / int'(r.distance);
         if (hu > 65535) hu = 65535;
      end
      if (hu == 0) return 0;
      hz = int'(horizon_reg);
      first = (2 * hz - hu) / 2;
      stop = (hu + 2 * hz) / 2;
      if (stop > SCREEN_HEIGHT) stop = SCREEN_HEIGHT;
      tcol = (tw * int'(r.wall_coord)) >> 16;
      for (y = (first < 0) ? 0 : first; y < stop; y++) begin
         trow = ((y - first) * th) / hu;
         if (trow >= th) trow = th - 1;
         span_row[n] = y[twcr_pkg::ROW_W-1:0];
         span_index[n] = 12'(trow * tw + tcol);
         n++;
      end
      return n;
   endfunction

   function automatic void render_beat(input twcr_pkg::req_payload_type r);
      twcr_pkg::rsp_payload_type p;
      int n;
      if (r.command == twcr_pkg::CMD_LOAD) begin
         if (int'(r.texel_address) < TEX_WORDS)
            texture_mem[{r.texture_select, r.texel_address}] = r.texel_value;
      end else begin
         n = trace_column(r);
         for (int i = 0; i < n; i++) begin
            p.pixel_column = r.column;
            p.pixel_row = span_row[i];
            p.pixel_color = texture_mem[{r.texture_select, span_index[i]}];
            p.last_pixel = (i == n - 1);
            expected_pixels.push_back(p);
         end
      end
   endfunction

   function automatic twcr_pkg::req_payload_type random_beat();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(twcr_pkg::req_payload_type)-1:0];
   endfunction

   function automatic void queue_beat(input twcr_pkg::req_payload_type r);
      stimulus_entry_type e;
      e.pause_here = 1'b0;
      e.beat = r;
      beats_to_send.push_back(e);
      beats_queued++;
   endfunction

   function automatic void push_load(input logic [twcr_pkg::SEL_W-1:0] sel,
                                     input logic [twcr_pkg::TADDR_W-1:0] addr,
                                     input logic [twcr_pkg::TEXEL_W-1:0] value);
      twcr_pkg::req_payload_type r;
      r = random_beat();
      r.command = twcr_pkg::CMD_LOAD;
      r.texture_select = sel;
      r.texel_address = addr;
      r.texel_value = value;
      if (int'(addr) < TEX_WORDS) texel_loaded[{sel, addr}] = 1'b1;
      queue_beat(r);
   endfunction

   // Texels that the column will read are loaded first, so that no draw
   // ever reads memory that was never written.
   function automatic void push_draw(input twcr_pkg::req_payload_type r);
      int n;
      n = trace_column(r);
      for (int i = 0; i < n; i++) begin
         if (!texel_loaded[{r.texture_select, span_index[i]}])
            push_load(r.texture_select, span_index[i], $urandom);
      end
      queue_beat(r);
   endfunction

   function automatic void push_column(input logic [twcr_pkg::SEL_W-1:0] sel,
                                       input logic [twcr_pkg::COL_W-1:0] col,
                                       input logic [twcr_pkg::DIST_W-1:0] wall_dist,
                                       input logic [twcr_pkg::COORD_W-1:0] coord);
      twcr_pkg::req_payload_type r;
      r = random_beat();
      r.command = twcr_pkg::CMD_DRAW;
      r.texture_select = sel;
      r.column = col;
      r.distance = wall_dist;
      r.wall_coord = coord;
      push_draw(r);
   endfunction

   task automatic write_register(input logic [1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         twcr_pkg::REG_HORIZON:    horizon_reg = data[twcr_pkg::ROW_W-1:0];
         twcr_pkg::REG_TEX_WIDTH:  width_reg = data[twcr_pkg::SIZE_W-1:0];
         twcr_pkg::REG_TEX_HEIGHT: height_reg = data[twcr_pkg::SIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_until_idle();
      while (!(beats_to_send.size() == 0 && !req_valid && expected_pixels.size() == 0))
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int hz, input int tw, input int th, input int budget,
                            input int gap, input int stall);
      twcr_pkg::req_payload_type r;
      stimulus_entry_type marker;
      int first_beat, pick, d;
      bit paused;
      wait_until_idle();
      write_register(twcr_pkg::REG_HORIZON, ($urandom & 32'hFFFF_FFC0) | hz);
      write_register(twcr_pkg::REG_TEX_WIDTH, ($urandom & 32'hFFFF_FF80) | tw);
      write_register(twcr_pkg::REG_TEX_HEIGHT, ($urandom & 32'hFFFF_FF80) | th);
      write_register(REG_UNUSED, $urandom);
      gap_pct = gap;
      stall_pct = stall;
      first_beat = beats_queued;
      paused = 1'b0;
      push_column(twcr_pkg::SEL_W'($urandom), twcr_pkg::COL_W'($urandom), 16'd16384,
                  twcr_pkg::COORD_W'($urandom));
      push_column(twcr_pkg::SEL_W'($urandom), twcr_pkg::COL_W'($urandom), 16'd0,
                  twcr_pkg::COORD_W'($urandom));
      while (beats_queued - first_beat < budget) begin
         if (!paused && beats_queued - first_beat >= budget / 2) begin
            marker = '0;
            marker.pause_here = 1'b1;
            beats_to_send.push_back(marker);
            paused = 1'b1;
         end
         r = random_beat();
         if ($urandom_range(0, 4) == 0) begin
            push_load(r.texture_select, r.texel_address, r.texel_value);
         end else begin
            r.command = twcr_pkg::CMD_DRAW;
            pick = $urandom_range(0, 9);
            if (pick == 1) begin
               r.distance = '0;
            end else if (pick != 0) begin
               d = $urandom_range(1, 16384) >> $urandom_range(0, 13);
               r.distance = d[twcr_pkg::DIST_W-1:0];
            end
            push_draw(r);
         end
      end
   endtask

   always @(posedge clock) begin : drive_beats
      stimulus_entry_type head;
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            render_beat(req_payload);
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
            end else if (beats_to_send.size() != 0) begin
               head = beats_to_send[0];
               if (head.pause_here) begin
                  if (expected_pixels.size() == 0) void'(beats_to_send.pop_front());
               end else if ($urandom_range(0, 99) < gap_pct) begin
                  send_gap <= $urandom_range(0, 3);
               end else begin
                  req_payload <= head.beat;
                  void'(beats_to_send.pop_front());
                  offer = 1'b1;
               end
            end
         end
         req_valid <= offer;
      end
   end

   always @(posedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_taken && rsp_valid) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_pixels
      twcr_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel beat, expected none, got %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_column", 32'(want.pixel_column),
                        32'(rsp_payload.pixel_column));
            check_field("pixel_row", 32'(want.pixel_row), 32'(rsp_payload.pixel_row));
            check_field("pixel_color", want.pixel_color, rsp_payload.pixel_color);
            check_field("last_pixel", 32'(want.last_pixel), 32'(rsp_payload.last_pixel));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin : main_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct = 20;
      push_load(2'd0, 12'd0, 32'h0000_0000);
      push_load(2'd3, 12'd4095, 32'hFFFF_FFFF);
      push_column(2'd0, 10'd0, 16'd0, 16'h0000);
      push_column(2'd1, 10'd1023, 16'd1, 16'hFFFF);
      push_column(2'd2, 10'd512, 16'd16384, 16'h8000);
      push_column(2'd3, 10'd7, 16'd16385, 16'h0000);
      push_column(2'd3, 10'd100, 16'hFFFF, 16'hFFFF);
      push_column(2'd2, 10'd300, 16'd8192, 16'h1234);
      push_column(2'd1, 10'd900, 16'd2048, 16'hC000);

      run_phase(32, 8, 8, 50, 30, 30);
      run_phase(0, 1, 1, 40, 20, 20);
      run_phase(63, 64, 64, 50, 10, 40);
      run_phase($urandom_range(0, 63), 0, 127, 40, 30, 10);
      run_phase($urandom_range(0, 63), 127, 0, 40, 0, 0);
      hold_request = 1'b1;
      run_phase($urandom_range(0, 63), $urandom_range(1, 16), $urandom_range(1, 16), 60, 25, 25);
      run_phase($urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 127),
                60, 40, 40);
      run_phase($urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 127),
                60, 15, 50);
      run_phase($urandom_range(0, 63), 4, 16, 50, 0, 0);

      wait_until_idle();
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/twcr_pkg.sv
src/twcr_csr.sv
src/twcr_div.sv
src/twcr_tex_store.sv
src/twcr_out_queue.sv
src/textured_wall_column_renderer.sv
src/twcr_checker.sv
tb/sv/testbench.sv
